// File: hdl/nfia_pkg.sv
// Shared types and codes for the next-fit ID bitmap allocator.
// No dependencies; used by the controller, the datapath and the top level.
`timescale 1ns / 1ps
`default_nettype none

package nfia_pkg;

  // bitmap word size
  localparam int WORD_BITS = 64;

  // request modes
  localparam logic MODE_ALLOC = 1'b0;
  localparam logic MODE_FREE  = 1'b1;

  // result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOT_USED = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  // controller to datapath commands
  typedef struct packed {
    logic clr;       // write one zero word of the clearing pass
    logic accept;    // latch the request word and set up the search
    logic free_rd;   // read the word that holds the freed ID
    logic free_wr;   // write it back with the bit cleared
    logic srch_rd;   // read the current search word
    logic srch_chk;  // check the search word, claim a bit on a hit
    logic load_out;  // move the result into the output register
  } nfia_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic clr_last;   // clearing pass is at its last word
    logic req_free;   // offered request is a free
    logic req_oor;    // offered free ID lies beyond the table
    logic no_ids;     // table has no allocatable IDs at all
    logic hit;        // search word holds a usable clear bit
    logic srch_last;  // search word is the final one of the sweep
    logic out_busy;   // output register holds a word not yet taken
  } nfia_sts_t;

endpackage

`default_nettype wire

// File: hdl/nfia_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module nfia_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 4
) (
  input  wire logic                                   clk,
  input  wire logic                                   we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  wire logic [WIDTH-1:0]                       wdata,
  output logic      [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write, then register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: hdl/nfia_ctrl.sv
// Controller state machine of the ID allocator: sequences clear, free and search.
// Depends on nfia_pkg.
`timescale 1ns / 1ps
`default_nettype none

module nfia_ctrl (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire nfia_pkg::nfia_sts_t sts,
  output nfia_pkg::nfia_cmd_t     cmd
);
  import nfia_pkg::*;

  typedef enum logic [6:0] {
    ST_CLEAR    = 7'b0000001,
    ST_IDLE     = 7'b0000010,
    ST_FREE_RD  = 7'b0000100,
    ST_FREE_WR  = 7'b0001000,
    ST_SRCH_RD  = 7'b0010000,
    ST_SRCH_CHK = 7'b0100000,
    ST_RESP     = 7'b1000000
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  // decode commands and next state
  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr = 1'b1;
        if (sts.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.req_free) begin
            state_next = sts.req_oor ? ST_RESP : ST_FREE_RD;
          end else begin
            state_next = sts.no_ids ? ST_RESP : ST_SRCH_RD;
          end
        end
      end
      ST_FREE_RD: begin
        cmd.free_rd = 1'b1;
        state_next  = ST_FREE_WR;
      end
      ST_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_next  = ST_RESP;
      end
      ST_SRCH_RD: begin
        cmd.srch_rd = 1'b1;
        state_next  = ST_SRCH_CHK;
      end
      ST_SRCH_CHK: begin
        cmd.srch_chk = 1'b1;
        if (sts.hit || sts.srch_last) begin
          state_next = ST_RESP;
        end else begin
          state_next = ST_SRCH_RD;
        end
      end
      ST_RESP: begin
        if (!sts.out_busy) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  // advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

`ifndef SYNTH
  // a word check always follows its read
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_CHK) |-> ($past(state) == ST_SRCH_RD))
    else $error("search check without read");

  // the output register is loaded only when free
  assert property (@(posedge clk) disable iff (rst)
    cmd.load_out |-> !sts.out_busy)
    else $error("result loaded over a waiting word");

  // the free write always follows its read
  assert property (@(posedge clk) disable iff (rst)
    cmd.free_wr |-> ($past(state) == ST_FREE_RD))
    else $error("free write without read");
`endif

endmodule

`default_nettype wire

// File: hdl/nfia_dpath.sv
// Datapath of the ID allocator: bitmap RAM, search pointer, word scan and result.
// Depends on nfia_pkg and nfia_ram.
`timescale 1ns / 1ps
`default_nettype none

module nfia_dpath #(
  parameter int MAX_IDS      = 256,
  parameter int RESERVED_IDS = 1
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire nfia_pkg::nfia_cmd_t cmd,
  output nfia_pkg::nfia_sts_t      sts,
  input  wire logic                mode,
  input  wire logic [7:0]          id_to_free,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic      [7:0]          id,
  output logic      [1:0]          status
);
  import nfia_pkg::*;

  localparam int IW    = (MAX_IDS > 256) ? $clog2(MAX_IDS) + 1 : 9;
  localparam int WORDS = (MAX_IDS + WORD_BITS - 1) / WORD_BITS;
  localparam int WA    = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int BW    = $clog2(WORD_BITS);
  localparam logic [IW-1:0] MaxIdx   = IW'(MAX_IDS);
  localparam logic [IW-1:0] ResIdx   = IW'(RESERVED_IDS);
  localparam logic [WA-1:0] LastWord = WA'(WORDS - 1);
  localparam logic [WA-1:0] ResWord  = WA'(RESERVED_IDS / WORD_BITS);
  localparam logic          NoIds    = (RESERVED_IDS >= MAX_IDS);

  logic [WA-1:0]        word;
  logic                 phase;
  logic [IW-1:0]        search_start;
  logic [7:0]           fid;
  logic [7:0]           res_id;
  logic [1:0]           res_status;

  logic                 ram_we;
  logic [WA-1:0]        ram_addr;
  logic [WORD_BITS-1:0] ram_wdata;
  logic [WORD_BITS-1:0] ram_rdata;

  logic [WA-1:0]        ptr_word;
  logic [WA-1:0]        fid_word;
  logic [BW-1:0]        fid_bit;
  logic [IW-1:0]        lo;
  logic [IW-1:0]        hi;
  logic [WORD_BITS-1:0] usable;
  logic                 hit;
  logic [BW-1:0]        hit_bit;
  logic [IW-1:0]        cand;
  logic [IW-1:0]        cand_inc;
  logic [IW-1:0]        ptr_next;
  logic                 was_used;

  assign ptr_word = WA'(search_start[IW-1:BW]);
  assign fid_word = WA'(fid[7:BW]);
  assign fid_bit  = fid[BW-1:0];

  // bounds of the current scan: upward from the pointer, then the wrapped part
  assign lo = phase ? ResIdx : search_start;
  assign hi = phase ? search_start : MaxIdx;

  // mark the clear bits that lie inside the scan bounds
  always_comb begin
    logic [IW-1:0] gidx;
    for (int b = 0; b < WORD_BITS; b++) begin
      gidx      = IW'({word, BW'(b)});
      usable[b] = !ram_rdata[b] && (gidx >= lo) && (gidx < hi);
    end
  end

  // pick the lowest usable bit
  always_comb begin
    hit     = 1'b0;
    hit_bit = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (usable[b]) begin
        hit     = 1'b1;
        hit_bit = BW'(b);
      end
    end
  end

  assign cand     = IW'({word, hit_bit});
  assign cand_inc = cand + IW'(1);
  assign ptr_next = (cand_inc >= MaxIdx) ? ResIdx : cand_inc;
  assign was_used = ram_rdata[fid_bit];

  // bitmap port select
  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = word;
    ram_wdata = '0;
    if (cmd.clr) begin
      ram_we = 1'b1;
    end else if (cmd.free_rd || cmd.free_wr) begin
      ram_addr  = fid_word;
      ram_we    = cmd.free_wr;
      ram_wdata = ram_rdata & ~(WORD_BITS'(1) << fid_bit);
    end else if (cmd.srch_chk) begin
      ram_we    = hit;
      ram_wdata = ram_rdata | (WORD_BITS'(1) << hit_bit);
    end
  end

  nfia_ram #(
    .WIDTH(WORD_BITS),
    .DEPTH(WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // status to the controller
  assign sts.clr_last  = (word == LastWord);
  assign sts.req_free  = (mode == MODE_FREE);
  assign sts.req_oor   = ({{(IW - 8){1'b0}}, id_to_free} >= MaxIdx);
  assign sts.no_ids    = NoIds;
  assign sts.hit       = hit;
  assign sts.srch_last = phase && (word == ptr_word);
  assign sts.out_busy  = out_valid && !out_ready;

  // scan word and phase
  always_ff @(posedge clk) begin
    if (rst) begin
      word  <= '0;
      phase <= 1'b0;
    end else if (cmd.clr) begin
      word <= word + WA'(1);
    end else if (cmd.accept) begin
      word  <= ptr_word;
      phase <= 1'b0;
    end else if (cmd.srch_chk && !hit) begin
      if (!phase && (word == LastWord)) begin
        phase <= 1'b1;
        word  <= ResWord;
      end else begin
        word <= word + WA'(1);
      end
    end
  end

  // hold the next-fit pointer
  always_ff @(posedge clk) begin
    if (rst) begin
      search_start <= ResIdx;
    end else if (cmd.srch_chk && hit) begin
      search_start <= ptr_next;
    end
  end

  // build the pending result
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      fid <= id_to_free;
      if (mode == MODE_FREE) begin
        res_id     <= id_to_free;
        res_status <= STATUS_NOT_USED;
      end else begin
        res_id     <= '0;
        res_status <= STATUS_FULL;
      end
    end else if (cmd.free_wr) begin
      res_status <= was_used ? STATUS_OK : STATUS_NOT_USED;
    end else if (cmd.srch_chk && hit) begin
      res_id     <= cand[7:0];
      res_status <= STATUS_OK;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      id     <= res_id;
      status <= res_status;
    end
  end

`ifndef SYNTH
  // the pointer never leaves the allocatable range
  assert property (@(posedge clk) disable iff (rst)
    !NoIds |-> ((search_start >= ResIdx) && (search_start < MaxIdx)))
    else $error("search pointer out of range");

  // a claimed bit turns into an ok result
  assert property (@(posedge clk) disable iff (rst)
    (cmd.srch_chk && hit) |=> (res_status == STATUS_OK))
    else $error("claimed ID without ok status");

  // a free write always clears the freed bit
  assert property (@(posedge clk) disable iff (rst)
    cmd.free_wr |-> !ram_wdata[fid_bit])
    else $error("free write leaves bit set");
`endif

endmodule

`default_nettype wire

// File: hdl/next_fit_id_bitmap_allocator_unit.sv
// Top level of the next-fit ID bitmap allocator: controller plus datapath.
// Depends on nfia_pkg, nfia_ctrl, nfia_dpath (and nfia_ram through it).
`timescale 1ns / 1ps
`default_nettype none

// Allocates and frees IDs out of a bitmap of MAX_IDS bits held in a single-port
// RAM of 64-bit words with registered read. After reset the block clears the
// bitmap one word per cycle, ceil(MAX_IDS/64) words (4 at the defaults), and
// accepts no word until then. One request is in flight at a time. A free
// reads the word, writes it back and loads the result, and goes straight to
// the load when the ID is beyond the table. An allocate scans the bitmap
// next-fit from the rotating pointer word by word (RAM read, then check and
// claim), stopping at the first word with room; on a full table it visits at
// most ceil(MAX_IDS/64) + 1 words.
// A finished result waits in an output register; the next request is taken
// while it waits.
module next_fit_id_bitmap_allocator_unit #(
  parameter int MAX_IDS      = 256,
  parameter int RESERVED_IDS = 1
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic       mode,
  input  wire logic [7:0] id_to_free,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic      [7:0] id,
  output logic      [1:0] status
);
  import nfia_pkg::*;

  nfia_cmd_t cmd;
  nfia_sts_t sts;

  nfia_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sts     (sts),
    .cmd     (cmd)
  );

  nfia_dpath #(
    .MAX_IDS     (MAX_IDS),
    .RESERVED_IDS(RESERVED_IDS)
  ) u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .mode      (mode),
    .id_to_free(id_to_free),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .id        (id),
    .status    (status)
  );

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for next_fit_id_bitmap_allocator_unit.
// Drives allocate/free words with random idling and stalls, predicts every result from a
// cycle-free model of the bitmap and the next-fit pointer. Depends on nfia_pkg and the RTL.
`timescale 1ns / 1ps

module tb;
  import nfia_pkg::*;

  localparam int TABLE_SIZE   = 256;
  localparam int RESERVED     = 1;
  localparam int SETTLE_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 600000;
  localparam int MAX_REPORTS  = 10;

  // idling phases
  localparam int PH_NONE     = 0;
  localparam int PH_SENDER   = 1;
  localparam int PH_RECEIVER = 2;
  localparam int PH_BOTH     = 3;

  typedef struct {
    logic       mode;
    logic [7:0] fid;
    int         phase;
  } id_request_t;

  typedef struct {
    logic [7:0] id;
    logic [1:0] status;
  } id_answer_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       mode = MODE_ALLOC;
  logic [7:0] id_to_free = 8'd0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] id;
  logic [1:0] status;

  id_request_t requests_waiting[$];
  id_answer_t  answers_due[$];
  int          active_phase = PH_NONE;
  int          mismatch_count = 0;
  int          cycle_count = 0;

  // shadow of the allocator state
  logic [TABLE_SIZE-1:0] ids_in_use;
  int unsigned           next_candidate;

  next_fit_id_bitmap_allocator_unit #(
    .MAX_IDS      (TABLE_SIZE),
    .RESERVED_IDS (RESERVED)
  ) DUT (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .mode       (mode),
    .id_to_free (id_to_free),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .id         (id),
    .status     (status)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // Work out the answer to one request and update the shadow state.
  function automatic id_answer_t allocate_or_free(input logic req_mode, input logic [7:0] fid);
    id_answer_t  ans;
    int unsigned ptr;
    int unsigned cand;
    ans.id = 8'd0;
    ans.status = STATUS_FULL;
    if (req_mode == MODE_FREE) begin
      ans.id = fid;
      if (fid >= TABLE_SIZE) begin
        ans.status = STATUS_NOT_USED;
      end else begin
        ans.status = ids_in_use[fid] ? STATUS_OK : STATUS_NOT_USED;
        ids_in_use[fid] = 1'b0;
      end
      return ans;
    end
    if (RESERVED >= TABLE_SIZE) return ans;
    ptr = next_candidate;
    if (ptr < RESERVED || ptr >= TABLE_SIZE) ptr = RESERVED;
    for (int i = 0; i < TABLE_SIZE - RESERVED; i++) begin
      cand = ptr;
      ptr = ptr + 1;
      if (ptr >= TABLE_SIZE) ptr = RESERVED;
      if (!ids_in_use[cand]) begin
        ids_in_use[cand] = 1'b1;
        next_candidate = ptr;
        ans.id = cand[7:0];
        ans.status = STATUS_OK;
        return ans;
      end
    end
    return ans;
  endfunction

  function automatic bit roll(input int unsigned pct);
    return $urandom_range(99, 0) < pct;
  endfunction

  function automatic bit sender_idles(input int ph);
    case (ph)
      PH_SENDER: return roll(82);
      PH_BOTH:   return roll(18);
      default:   return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls(input int ph);
    case (ph)
      PH_RECEIVER: return roll(82);
      PH_BOTH:     return roll(18);
      default:     return 1'b0;
    endcase
  endfunction

  task automatic queue_request(input logic req_mode, input logic [7:0] fid, input int ph);
    id_request_t r;
    r.mode = req_mode;
    r.fid = fid;
    r.phase = ph;
    requests_waiting.push_back(r);
  endtask

  // Allocates carry a random, ignored ID field.
  task automatic queue_allocs(input int count, input int ph);
    for (int i = 0; i < count; i++) queue_request(MODE_ALLOC, 8'($urandom_range(255, 0)), ph);
  endtask

  task automatic queue_mix(input int count, input int alloc_pct, input int ph);
    for (int i = 0; i < count; i++) begin
      if (roll(alloc_pct)) queue_request(MODE_ALLOC, 8'($urandom_range(255, 0)), ph);
      else queue_request(MODE_FREE, 8'($urandom_range(255, 0)), ph);
    end
  endtask

  task automatic report_mismatch(input string what, input id_answer_t want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("%0t: %s: expected id %0d status %0d, got id %0d status %0d",
               $realtime, what, want.id, want.status, id, status);
    end
  endtask

  // Send words from the pending queue; predict each one as it is taken.
  always @(posedge clk) begin : send_proc
    id_request_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) answers_due.push_back(allocate_or_free(mode, id_to_free));
      if (!in_valid || in_ready) begin
        if (requests_waiting.size() > 0 && !sender_idles(requests_waiting[0].phase)) begin
          nxt = requests_waiting.pop_front();
          in_valid <= 1'b1;
          mode <= nxt.mode;
          id_to_free <= nxt.fid;
          active_phase <= nxt.phase;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Take result words and check them against the oldest prediction.
  always @(posedge clk) begin : take_proc
    id_answer_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (answers_due.size() == 0) begin
          want.id = 8'd0;
          want.status = 2'd0;
          report_mismatch("result with nothing outstanding", want);
        end else begin
          want = answers_due.pop_front();
          if (id !== want.id || status !== want.status) report_mismatch("result mismatch", want);
        end
      end
      out_ready <= !receiver_stalls(active_phase);
    end
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    ids_in_use = '0;
    next_candidate = RESERVED;

    // directed: first IDs, next-fit order, frees of used, unused and reserved IDs
    queue_request(MODE_ALLOC, 8'hFF, PH_NONE);
    queue_request(MODE_ALLOC, 8'h00, PH_NONE);
    queue_request(MODE_ALLOC, 8'hAA, PH_NONE);
    queue_request(MODE_FREE, 8'd2, PH_NONE);
    queue_request(MODE_FREE, 8'd2, PH_NONE);
    queue_request(MODE_FREE, 8'h00, PH_NONE);
    queue_request(MODE_FREE, 8'hFF, PH_NONE);
    queue_request(MODE_FREE, 8'hAA, PH_NONE);
    queue_request(MODE_FREE, 8'h55, PH_NONE);
    queue_request(MODE_ALLOC, 8'h55, PH_NONE);
    queue_request(MODE_FREE, 8'd1, PH_NONE);
    queue_request(MODE_FREE, 8'd3, PH_NONE);
    queue_request(MODE_FREE, 8'd4, PH_NONE);
    queue_request(MODE_ALLOC, 8'h00, PH_NONE);
    queue_request(MODE_FREE, 8'd5, PH_NONE);
    queue_request(MODE_FREE, 8'd5, PH_NONE);

    // fill past full, then churn so frees mostly hit and allocs wrap
    queue_allocs(262, PH_NONE);
    queue_mix(180, 50, PH_NONE);
    queue_mix(160, 0, PH_SENDER);
    queue_mix(280, 60, PH_SENDER);
    queue_mix(440, 50, PH_RECEIVER);
    queue_allocs(100, PH_BOTH);
    queue_mix(340, 45, PH_BOTH);

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    wait (requests_waiting.size() == 0 && !in_valid && answers_due.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
